@@ design/btb_pkg.sv @@
// Package for the two-level branch predictor with branch target buffer.
// Holds register indexes, operation codes and sizing constants; no dependencies.
package btb_pkg;
	localparam int BTB_ENTRIES_DEF = 32;
	localparam int MAX_HISTORY_DEF = 8;
	localparam int PC_W = 32;
	localparam int TAG_W = 30;

	localparam logic [2:0] REG_HISTORY_LENGTH = 3'd0;
	localparam logic [2:0] REG_TAG_LENGTH     = 3'd1;
	localparam logic [2:0] REG_INITIAL_CTR    = 3'd2;
	localparam logic [2:0] REG_HISTORY_GLOBAL = 3'd3;
	localparam logic [2:0] REG_TABLE_GLOBAL   = 3'd4;
	localparam logic [2:0] REG_SHARE_MODE     = 3'd5;

	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;

	localparam logic [1:0] SHARE_NONE = 2'd0;
	localparam logic [1:0] SHARE_LOW  = 2'd1;
	localparam logic [1:0] SHARE_HIGH = 2'd2;

	// Lowest PC bit of the high share field.
	localparam int SHARE_HIGH_LSB = 16;
endpackage

@@ design/btb_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module btb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

@@ design/btb_two_level_branch_predictor_top.sv @@
// Top level of the two-level branch predictor with branch target buffer.
// Depends on btb_pkg and btb_ram.
//
// Usage:
//   s_tvalid/s_tready/s_tdata/s_tuser carry one request per beat; s_tuser is
//   the operation (0 predict, 1 update). m_tvalid/m_tready/m_tdata return one
//   result per request. Configuration writes go through cfg_we/cfg_index/
//   cfg_data; any valid write reinitializes all predictor state.
// Timing:
//   A request goes through accept, read counter RAM, compute and write back,
//   then presents the result. An update that allocates a new entry with
//   per-entry counter rows first sweeps the row, one counter per cycle, on
//   the single counter RAM port.
// Reset and configuration:
//   After reset, and after every configuration write, the counter RAM is swept
//   to initial_counter one counter per cycle; s_tready stays low meanwhile.
// Stalls:
//   A result waits in the output register until m_tready; the next request is
//   accepted once the result is taken.
module btb_two_level_branch_predictor_top
	import btb_pkg::*;
#(
	parameter int BTB_ENTRIES = BTB_ENTRIES_DEF,
	parameter int MAX_HISTORY = MAX_HISTORY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: pc[31:0], actual_target[63:32], taken[64], earlier_prediction[96:65]
	input  logic [103:0] s_tdata,
	// s_tuser: operation
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: predicted_taken[0], next_pc[32:1], flushed[33],
	//          branch_count[65:34], flush_count[97:66]
	output logic [103:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	localparam int IB = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES + 1) - 1 : 0;
	localparam int SW = (IB > 0) ? IB : 1;
	localparam int ROW = 1 << MAX_HISTORY;
	localparam int CDEPTH = BTB_ENTRIES * ROW;
	localparam int CAW = $clog2(CDEPTH + 1) > 0 ? $clog2(CDEPTH) : 1;
	localparam int CAWX = (CAW > 0) ? CAW : 1;
	localparam int HLW = $clog2(MAX_HISTORY + 1);

	typedef enum logic [6:0] {
		ST_INIT  = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_ALLOC = 7'b0000100,
		ST_READ  = 7'b0001000,
		ST_CALC  = 7'b0010000,
		ST_WRITE = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [3:0] hlen_cfg_q;
	logic [4:0] tlen_q;
	logic [1:0] init_q;
	logic       hglob_q, tglob_q;
	logic [1:0] share_q;

	// entry storage (small, flops with valid bits)
	logic              valid_q [BTB_ENTRIES];
	logic [TAG_W-1:0]  tag_q   [BTB_ENTRIES];
	logic [PC_W-1:0]   tgt_q   [BTB_ENTRIES];
	logic [MAX_HISTORY-1:0] lhist_q [BTB_ENTRIES];
	logic [MAX_HISTORY-1:0] ghist_q;
	logic [31:0] upd_q, fl_q;

	// request
	logic        op_q, tk_q;
	logic [31:0] pc_q, at_q, ep_q;
	logic [SW-1:0] slot_q;
	logic [CAWX-1:0] pos_q, sweep_q;
	logic [MAX_HISTORY:0] acnt_q;
	logic [103:0] out_q;

	// effective history length
	logic [HLW-1:0] hl;
	always_comb begin
		if (hlen_cfg_q == 4'd0) hl = HLW'(1);
		else if (32'(hlen_cfg_q) > MAX_HISTORY) hl = HLW'(MAX_HISTORY);
		else hl = HLW'(hlen_cfg_q);
	end
	logic [MAX_HISTORY-1:0] hmask;
	assign hmask = MAX_HISTORY'((32'd1 << hl) - 32'd1);

	// decode of incoming beat
	logic [31:0] in_pc;
	logic [SW-1:0] in_slot;
	logic [TAG_W-1:0] in_tag;
	logic [63:0] tmask;
	assign in_pc = s_tdata[31:0];
	assign in_slot = (IB > 0) ? SW'(in_pc >> 2) : '0;
	assign tmask = (64'd1 << tlen_q) - 64'd1;
	assign in_tag = TAG_W'(64'(in_pc >> (2 + IB)) & tmask);
	logic hit;
	assign hit = valid_q[in_slot] && tag_q[in_slot] == in_tag;

	// counter position for the latched request
	logic [MAX_HISTORY-1:0] cur_h, idx;
	logic [CAWX-1:0] pos_c;
	always_comb begin
		cur_h = (hglob_q ? ghist_q : lhist_q[slot_q]) & hmask;
		idx = cur_h;
		case (share_q)
			SHARE_LOW:  idx = cur_h ^ (MAX_HISTORY'(pc_q >> 2) & hmask);
			SHARE_HIGH: idx = cur_h ^ (MAX_HISTORY'(pc_q >> SHARE_HIGH_LSB) & hmask);
			default:    idx = cur_h;
		endcase
		if (tglob_q) pos_c = CAWX'(idx);
		else pos_c = CAWX'((32'(slot_q) << hl) + 32'(idx));
	end

	// counter RAM
	logic ram_we;
	logic [CAWX-1:0] ram_addr;
	logic [1:0] ram_wd, ram_rd;
	btb_ram #(.WIDTH(2), .DEPTH(CDEPTH)) u_ctr (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
	);

	logic [1:0] stepped;
	always_comb begin
		stepped = ram_rd;
		if (tk_q) begin
			if (ram_rd != 2'd3) stepped = ram_rd + 2'd1;
		end else if (ram_rd != 2'd0) stepped = ram_rd - 2'd1;
	end

	always_comb begin
		ram_we = 1'b0;
		ram_addr = pos_q;
		ram_wd = init_q;
		case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
				ram_addr = sweep_q;
			end
			ST_ALLOC: begin
				ram_we = 1'b1;
				ram_addr = CAWX'((32'(slot_q) << hl) + 32'(acnt_q));
			end
			ST_WRITE: begin
				ram_we = op_q;
				ram_wd = stepped;
			end
			default: ram_addr = pos_q;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata = out_q;

	logic pred_tk, flush;
	assign pred_tk = ep_q != pc_q + 32'd4;
	assign flush = (pred_tk != tk_q) || (tk_q && ep_q != at_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			hlen_cfg_q <= 4'd2;
			tlen_q <= 5'd8;
			init_q <= 2'd1;
			hglob_q <= 1'b0;
			tglob_q <= 1'b0;
			share_q <= SHARE_NONE;
			sweep_q <= '0;
			ghist_q <= '0;
			upd_q <= '0;
			fl_q <= '0;
			for (int i = 0; i < BTB_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				lhist_q[i] <= '0;
			end
		end else if (cfg_we && cfg_index <= REG_SHARE_MODE) begin
			// register write: reinitialize everything
			case (cfg_index)
				REG_HISTORY_LENGTH: hlen_cfg_q <= cfg_data[3:0];
				REG_TAG_LENGTH:     tlen_q <= cfg_data;
				REG_INITIAL_CTR:    init_q <= cfg_data[1:0];
				REG_HISTORY_GLOBAL: hglob_q <= cfg_data[0];
				REG_TABLE_GLOBAL:   tglob_q <= cfg_data[0];
				default:            share_q <= cfg_data[1:0];
			endcase
			state_q <= ST_INIT;
			sweep_q <= '0;
			ghist_q <= '0;
			upd_q <= '0;
			fl_q <= '0;
			for (int i = 0; i < BTB_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				lhist_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (32'(sweep_q) == CDEPTH - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_tvalid) begin
					op_q <= s_tuser;
					pc_q <= in_pc;
					at_q <= s_tdata[63:32];
					tk_q <= s_tdata[64];
					ep_q <= s_tdata[96:65];
					slot_q <= in_slot;
					acnt_q <= '0;
					// predict miss: taken bit is cleared now; the counter does not affect its result
					out_q <= {103'd0, hit};
					if (s_tuser == OP_UPDATE && !hit) begin
						valid_q[in_slot] <= 1'b1;
						tag_q[in_slot] <= in_tag;
						if (!hglob_q) lhist_q[in_slot] <= '0;
						state_q <= tglob_q ? ST_READ : ST_ALLOC;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_ALLOC: begin
					acnt_q <= acnt_q + 1'b1;
					if (32'(acnt_q) == (32'd1 << hl) - 1) state_q <= ST_READ;
				end
				ST_READ: begin
					pos_q <= pos_c;
					state_q <= ST_CALC;
				end
				ST_CALC: state_q <= ST_WRITE;
				ST_WRITE: begin
					if (op_q == OP_PREDICT) begin
						out_q[0] <= out_q[0] && ram_rd[1];
						out_q[32:1] <= (out_q[0] && ram_rd[1]) ? tgt_q[slot_q]
							: pc_q + 32'd4;
						out_q[65:34] <= upd_q;
						out_q[97:66] <= fl_q;
					end else begin
						tgt_q[slot_q] <= at_q;
						if (hglob_q) ghist_q <= ((cur_h << 1) | MAX_HISTORY'(tk_q)) & hmask;
						else lhist_q[slot_q] <= ((cur_h << 1) | MAX_HISTORY'(tk_q)) & hmask;
						upd_q <= upd_q + 32'd1;
						if (flush) fl_q <= fl_q + 32'd1;
						out_q[0] <= 1'b0;
						out_q[33] <= flush;
						out_q[65:34] <= upd_q + 32'd1;
						out_q[97:66] <= fl_q + 32'(flush);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_INIT;
			endcase
		end
	end
endmodule
